FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is active.
`define EPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define EPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/epc_pkg.sv
`default_nettype none
package epc_pkg;

  localparam int unsigned DAY_W = 16;

  // reciprocal multipliers: n/60 = (n*DIV60_MAGIC) >> 37, n/24 = (n*DIV24_MAGIC) >> 36,
  // exact for every 32-bit n
  localparam logic [31:0]      DIV60_MAGIC = 32'h8888_8889;
  localparam logic [31:0]      DIV24_MAGIC = 32'hAAAA_AAAB;
  localparam logic [DAY_W-1:0] DAYS_COMMON = 16'd365;
  localparam logic [DAY_W-1:0] FEB_END_DOY = 16'd58;   // 30 + 28
  localparam logic [16:0]      OFFSET_RESET = 17'sd7200;

  // 1970 taken mod 4, 100 and 400
  localparam logic [1:0] Y0_MOD4   = 2'd2;
  localparam logic [6:0] Y0_MOD100 = 7'd70;
  localparam logic [8:0] Y0_MOD400 = 9'd370;

  typedef struct packed {
    logic             ge;
    logic [DAY_W-1:0] diff;
  } sub_res_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m) inside
      4'd1:                      len = 5'd29;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

FILE: src/epc_sub_unit.sv
`default_nettype none
module epc_sub_unit (
  input  wire logic [15:0]      a,
  input  wire logic [15:0]      b,
  output epc_pkg::sub_res_t     res
);
  import epc_pkg::*;

  logic [DAY_W:0] wide;

  // borrow out clear means a >= b
  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~wide[DAY_W];
  assign res.diff = wide[DAY_W-1:0];

endmodule
`default_nettype wire

FILE: src/epoch_seconds_to_calendar_unit.sv
`default_nettype none
// Converts a 32-bit Unix seconds count plus the signed local offset
// (local_offset_seconds, written through offset_we) into local Gregorian
// date and time. Pulse start while busy is low; the transaction is taken
// at that edge and busy stays high until the result is ready. The result
// appears on the output ports with done high for exactly one cycle; the
// receiver cannot stall it, so it must capture the fields on that edge.
// Steps: the time of day comes from three reciprocal-multiply divisions
// (by 60, 60, 24) in S_DIV_SEC, S_DIV_MIN and S_DIV_HOUR. The shared
// subtract/compare unit then walks whole years in S_YEAR and months in
// S_MONTH. A new transaction may start in the done cycle.
module epoch_seconds_to_calendar_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        offset_we,
  input  wire logic [16:0] local_offset_seconds,
  input  wire logic        start,
  input  wire logic [31:0] epoch_seconds,
  output logic             busy,
  output logic             done,
  output logic [5:0]       second,
  output logic [5:0]       minute,
  output logic [4:0]       hour,
  output logic [7:0]       years_since_1970,
  output logic [3:0]       month,
  output logic [4:0]       day_of_month,
  output logic [10:0]      minutes_of_day
);
  import epc_pkg::*;

`include "assert_macros.svh"

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIV_SEC  = 3'd1;
  localparam logic [2:0] S_DIV_MIN  = 3'd2;
  localparam logic [2:0] S_DIV_HOUR = 3'd3;
  localparam logic [2:0] S_YEAR     = 3'd4;
  localparam logic [2:0] S_MONTH    = 3'd5;

  logic [2:0]  state;
  logic [16:0] offset;

  // divider datapath: quo holds the running dividend, then the quotient
  logic [31:0] quo;
  logic [31:0] magic;
  logic [63:0] prod;
  logic [31:0] quo_next;
  logic [5:0]  rem60;
  logic [4:0]  rem24;

  logic [5:0]       sec_r;
  logic [5:0]       min_r;
  logic [4:0]       hour_r;
  logic [DAY_W-1:0] days;
  logic [7:0]       years;
  logic [3:0]       mon;
  logic [1:0]       ymod4;
  logic [6:0]       ymod100;
  logic [8:0]       ymod400;

  logic [DAY_W-1:0] ua;
  logic [DAY_W-1:0] ub;
  sub_res_t         ures;

  logic        leap;

  assign busy = (state != S_IDLE);

  // Gregorian rule on the running year
  assign leap = (ymod4 == 2'd0) && ((ymod100 != 7'd0) || (ymod400 == 9'd0));

  // one division per cycle by reciprocal multiplication
  assign magic    = (state == S_DIV_HOUR) ? DIV24_MAGIC : DIV60_MAGIC;
  assign prod     = 64'(quo) * 64'(magic);
  assign quo_next = (state == S_DIV_HOUR) ? {4'd0, prod[63:36]} : {5'd0, prod[63:37]};
  // remainder from low bits: n - 60q == n + 4q (mod 64), n - 24q == n + 8q (mod 32)
  assign rem60    = quo[5:0] + {quo_next[3:0], 2'b00};
  assign rem24    = quo[4:0] + {quo_next[1:0], 3'b000};

  // operand select for the shared unit
  always_comb begin
    ua = days;
    ub = DAYS_COMMON;
    unique case (state)
      S_YEAR: begin
        ub = DAYS_COMMON + {15'd0, leap};
      end
      S_MONTH: begin
        ub = {11'd0, month_len(mon)};
      end
      default: begin
        ub = DAYS_COMMON;
      end
    endcase
  end

  epc_sub_unit u_sub (
    .a   (ua),
    .b   (ub),
    .res (ures)
  );

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= OFFSET_RESET;
    end else if (offset_we) begin
      offset <= local_offset_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_DIV_SEC;
          end
        end
        S_DIV_SEC: begin
          state <= S_DIV_MIN;
        end
        S_DIV_MIN: begin
          state <= S_DIV_HOUR;
        end
        S_DIV_HOUR: begin
          state <= S_YEAR;
        end
        S_YEAR: begin
          if (!ures.ge) state <= S_MONTH;
        end
        S_MONTH: begin
          if (!(ures.ge && (mon < 4'd11))) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          // sum wraps mod 2^32
          quo <= epoch_seconds + {{15{offset[16]}}, offset};
        end
      end
      S_DIV_SEC: begin
        quo   <= quo_next;
        sec_r <= rem60;
      end
      S_DIV_MIN: begin
        quo   <= quo_next;
        min_r <= rem60;
      end
      S_DIV_HOUR: begin
        hour_r  <= rem24;
        days    <= quo_next[DAY_W-1:0];
        years   <= 8'd0;
        ymod4   <= Y0_MOD4;
        ymod100 <= Y0_MOD100;
        ymod400 <= Y0_MOD400;
      end
      S_YEAR: begin
        if (ures.ge) begin
          days    <= ures.diff;
          years   <= years + 8'd1;
          ymod4   <= ymod4 + 2'd1;
          ymod100 <= (ymod100 == 7'd99)  ? 7'd0 : ymod100 + 7'd1;
          ymod400 <= (ymod400 == 9'd399) ? 9'd0 : ymod400 + 9'd1;
        end else begin
          // common year: step over Feb 29 in the month table
          days <= days + {15'd0, (!leap && (days > FEB_END_DOY))};
          mon  <= 4'd0;
        end
      end
      S_MONTH: begin
        if (ures.ge && (mon < 4'd11)) begin
          days <= ures.diff;
          mon  <= mon + 4'd1;
        end else begin
          second           <= sec_r;
          minute           <= min_r;
          hour             <= hour_r;
          years_since_1970 <= years;
          month            <= mon + 4'd1;
          day_of_month     <= days[4:0] + 5'd1;
          minutes_of_day   <= 11'(hour_r) * 11'd60 + 11'(min_r);
        end
      end
      default: begin
      end
    endcase
  end

  `EPC_ASSERT(a_done_idle, clk, rst, done |-> !busy, "result strobe while busy")
  `EPC_ASSERT(a_start_busy, clk, rst, (start && !busy) |=> busy, "start not taken")
  `EPC_ASSERT(a_done_pulse, clk, rst, done |=> !done, "result strobe longer than one cycle")
  `EPC_ASSERT(a_fields, clk, rst,
    done |-> ((month != 4'd0) && (month <= 4'd12) && (day_of_month != 5'd0) &&
              (hour <= 5'd23) && (years_since_1970 <= 8'd136)),
    "result field out of range")

endmodule
`default_nettype wire
